// ===== hw/rtl/drtfl_pkg.sv =====
// Shared constants and types for the dated rate table with floor lookup.
`timescale 1ns / 1ps
package drtfl_pkg;

	localparam int TABLE_DEPTH   = 1024;
	localparam int FRACTION_BITS = 16;
	localparam int ADDR_W        = $clog2(TABLE_DEPTH);
	localparam int COUNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 7;
	localparam int DAY_W    = 7;
	localparam int KMONTH_W = 4;
	localparam int KDAY_W   = 5;
	localparam int KEY_W    = YEAR_W + KMONTH_W + KDAY_W;
	localparam int VALUE_W  = 41;
	localparam int RATE_W   = 40;
	localparam int PROD_W   = 50;

	localparam int MAX_QUANTITY = 1000;
	localparam int QTY_W        = $clog2((MAX_QUANTITY << FRACTION_BITS) + 1);
	localparam logic [VALUE_W-1:0] QTY_LIMIT = VALUE_W'(MAX_QUANTITY) << FRACTION_BITS;
	localparam int SUM_W = (QTY_W + RATE_W > FRACTION_BITS + PROD_W) ?
		(QTY_W + RATE_W) : (FRACTION_BITS + PROD_W);

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		STS_INSERTED  = 3'd0,
		STS_RESULT    = 3'd1,
		STS_BAD_DATE  = 3'd2,
		STS_DUPLICATE = 3'd3,
		STS_BAD_VALUE = 3'd4,
		STS_NO_DATA   = 3'd5,
		STS_FULL      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_MUL,
		ST_FINISH
	} fsm_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [RATE_W-1:0] rate;
	} entry_t;

	typedef struct packed {
		logic              done;
		logic              dup;
		logic              found;
		logic [KEY_W-1:0]  best_key;
		logic [RATE_W-1:0] best_rate;
	} scan_res_t;

endpackage

// ===== hw/rtl/dated_rate_table_floor_lookup.sv =====
// Top level of the dated rate table: control sequencer, entry memory, scanner and multiplier.
`timescale 1ns / 1ps
// Items are handled one at a time. An insert or a query that passes its checks scans the
// stored entries through the single read port of the entry memory, one entry per cycle;
// a query then passes through the multiplier. A new item is taken while the previous
// result still waits in the output register. The table starts empty after reset and
// needs no clearing pass.
module dated_rate_table_floor_lookup
	import drtfl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	input  logic [YEAR_W-1:0]   year,
	input  logic [MONTH_W-1:0]  month,
	input  logic [DAY_W-1:0]    day,
	input  logic signed [VALUE_W-1:0] value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic [PROD_W-1:0]   product,
	output logic                exact_match,
	output logic [YEAR_W-1:0]   matched_year,
	output logic [KMONTH_W-1:0] matched_month,
	output logic [KDAY_W-1:0]   matched_day
);

	fsm_t                state_q;
	fsm_t                state_d;
	logic [COUNT_W-1:0]  count_q;

	op_t                 op_q;
	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DAY_W-1:0]    day_q;
	logic [VALUE_W-1:0]  value_q;
	logic [KEY_W-1:0]    key;
	logic                date_ok;
	logic                neg;
	logic                over;

	logic                scan_start;
	logic                mul_start;
	logic                wr_en;
	logic                res_load;
	status_t             res_status_d;
	status_t             res_status_q;
	logic [PROD_W-1:0]   res_product_q;
	logic                res_exact_q;
	logic [KEY_W-1:0]    res_key_q;

	logic                out_valid_q;
	status_t             out_status_q;
	logic [PROD_W-1:0]   out_product_q;
	logic                out_exact_q;
	logic [KEY_W-1:0]    out_key_q;
	logic                out_load;

	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	entry_t              rd_data;
	entry_t              wr_data;
	scan_res_t           scan_res;
	logic                mul_done;
	logic [PROD_W-1:0]   mul_product;

	assign in_stall = (state_q != ST_IDLE);
	assign key      = {year_q, month_q[KMONTH_W-1:0], day_q[KDAY_W-1:0]};
	assign neg      = value_q[VALUE_W-1];
	assign over     = value_q > QTY_LIMIT;
	assign wr_data  = '{key: key, rate: value_q[RATE_W-1:0]};
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	drtfl_date_check u_date (
		.year  (year_q),
		.month (month_q),
		.day   (day_q),
		.ok    (date_ok)
	);

	drtfl_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[ADDR_W-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	drtfl_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.key     (key),
		.count   (count_q),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (scan_res)
	);

	drtfl_mult u_mult (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.qty     (value_q[QTY_W-1:0]),
		.rate    (scan_res.best_rate),
		.done    (mul_done),
		.product (mul_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		scan_start   = 1'b0;
		mul_start    = 1'b0;
		wr_en        = 1'b0;
		res_load     = 1'b0;
		res_status_d = STS_INSERTED;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!date_ok) begin
					res_load     = 1'b1;
					res_status_d = STS_BAD_DATE;
					state_d      = ST_FINISH;
				end else if ((op_q == OP_QUERY) && (neg || over)) begin
					res_load     = 1'b1;
					res_status_d = STS_BAD_VALUE;
					state_d      = ST_FINISH;
				end else begin
					scan_start = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_res.done) begin
					if (op_q == OP_INSERT) begin
						res_load = 1'b1;
						state_d  = ST_FINISH;
						priority if (scan_res.dup) begin
							res_status_d = STS_DUPLICATE;
						end else if (neg) begin
							res_status_d = STS_BAD_VALUE;
						end else if (count_q == COUNT_W'(TABLE_DEPTH)) begin
							res_status_d = STS_FULL;
						end else begin
							res_status_d = STS_INSERTED;
							wr_en        = 1'b1;
						end
					end else if (!scan_res.found) begin
						res_load     = 1'b1;
						res_status_d = STS_NO_DATA;
						state_d      = ST_FINISH;
					end else begin
						mul_start = 1'b1;
						state_d   = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					res_load     = 1'b1;
					res_status_d = STS_RESULT;
					state_d      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_q    <= op_t'(op);
			year_q  <= year;
			month_q <= month;
			day_q   <= day;
			value_q <= value;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			if (res_status_d == STS_RESULT) begin
				res_product_q <= mul_product;
				res_exact_q   <= (scan_res.best_key == key);
				res_key_q     <= scan_res.best_key;
			end else begin
				res_product_q <= '0;
				res_exact_q   <= 1'b0;
				res_key_q     <= '0;
			end
		end
		if (out_load) begin
			out_status_q  <= res_status_q;
			out_product_q <= res_product_q;
			out_exact_q   <= res_exact_q;
			out_key_q     <= res_key_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign product       = out_product_q;
	assign exact_match   = out_exact_q;
	assign matched_year  = out_key_q[KEY_W-1 -: YEAR_W];
	assign matched_month = out_key_q[KDAY_W +: KMONTH_W];
	assign matched_day   = out_key_q[KDAY_W-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds the table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
		else $error("entry count changed by other than one");

	a_write_at_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((state_q == ST_SCAN) && scan_res.done && !scan_res.dup
			&& (op_q == OP_INSERT)))
		else $error("table write outside the end of an insert scan");

	a_no_result_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_status_q != STS_RESULT)) |->
			((product == '0) && !exact_match && (out_key_q == '0)))
		else $error("result fields set on a transfer without a result");

endmodule

// ===== hw/rtl/drtfl_date_check.sv =====
// Calendar date validation with the Gregorian leap year rule.
`timescale 1ns / 1ps
module drtfl_date_check
	import drtfl_pkg::*;
(
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               ok
);

	localparam logic [12:0] Recip100 = 13'd5243;
	localparam int Recip100Shift = 19;
	localparam int PRODW = YEAR_W + 13;
	localparam logic [YEAR_W-1:0] MinYear = YEAR_W'(2009);
	localparam logic [YEAR_W-1:0] MaxYear = YEAR_W'(9999);

	logic [PRODW-1:0]     recip_prod;
	logic [7:0]           cent;
	logic [14:0]          cent_x100;
	logic [YEAR_W-1:0]    cent_rem;
	logic                 leap;
	logic [DAY_W-1:0]     month_len;

	always_comb begin
		recip_prod = PRODW'(year) * PRODW'(Recip100);
		cent       = recip_prod[Recip100Shift +: 8];
		cent_x100  = 15'(cent) * 15'd100;
		cent_rem   = year - cent_x100[YEAR_W-1:0];
		leap       = (year[1:0] == 2'b00) && ((cent_rem != '0) || (cent[1:0] == 2'b00));
		unique case (month)
			7'd4, 7'd6, 7'd9, 7'd11: month_len = 7'd30;
			7'd2:                    month_len = leap ? 7'd29 : 7'd28;
			default:                 month_len = 7'd31;
		endcase
		ok = (year >= MinYear) && (year <= MaxYear) && (month >= 7'd1) && (month <= 7'd12)
			&& (day >= 7'd1) && (day <= month_len);
	end

endmodule

// ===== hw/rtl/drtfl_table.sv =====
// Entry memory holding one date key and one rate per table slot.
`timescale 1ns / 1ps
module drtfl_table
	import drtfl_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/drtfl_scan.sv =====
// Table scanner that reads every stored entry once and tracks duplicate and floor match.
`timescale 1ns / 1ps
module drtfl_scan
	import drtfl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [KEY_W-1:0]   key,
	input  logic [COUNT_W-1:0] count,
	output logic               rd_en,
	output logic [ADDR_W-1:0]  rd_addr,
	input  entry_t             rd_data,
	output scan_res_t          res
);

	logic               busy_q;
	logic [COUNT_W-1:0] idx_q;
	logic               rd_v_s1;
	logic               dup_q;
	logic               found_q;
	logic [KEY_W-1:0]   best_key_q;
	logic [RATE_W-1:0]  best_rate_q;
	logic               done;

	assign rd_en   = busy_q && (idx_q < count);
	assign rd_addr = idx_q[ADDR_W-1:0];
	assign done    = busy_q && (idx_q == count) && !rd_v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			dup_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (start) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			rd_v_s1 <= 1'b0;
			dup_q   <= 1'b0;
			found_q <= 1'b0;
		end else if (busy_q) begin
			rd_v_s1 <= rd_en;
			if (rd_en) begin
				idx_q <= idx_q + 1'b1;
			end
			if (rd_v_s1) begin
				if (rd_data.key == key) begin
					dup_q <= 1'b1;
				end
				if ((rd_data.key <= key) && (!found_q || (rd_data.key > best_key_q))) begin
					found_q <= 1'b1;
				end
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && rd_v_s1 && (rd_data.key <= key)
				&& (!found_q || (rd_data.key > best_key_q))) begin
			best_key_q  <= rd_data.key;
			best_rate_q <= rd_data.rate;
		end
	end

	always_comb begin
		res.done      = done;
		res.dup       = dup_q;
		res.found     = found_q;
		res.best_key  = best_key_q;
		res.best_rate = best_rate_q;
	end

endmodule

// ===== hw/rtl/drtfl_mult.sv =====
// Two-stage quantity by rate multiplier built from two partial products.
`timescale 1ns / 1ps
module drtfl_mult
	import drtfl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QTY_W-1:0]  qty,
	input  logic [RATE_W-1:0] rate,
	output logic              done,
	output logic [PROD_W-1:0] product
);

	localparam int RateLoW = RATE_W / 2;
	localparam int RateHiW = RATE_W - RateLoW;

	logic                       v_s1;
	logic                       v_s2;
	logic [QTY_W+RateLoW-1:0]   pp_lo_s1;
	logic [QTY_W+RateHiW-1:0]   pp_hi_s1;
	logic [SUM_W-1:0]           sum;
	logic [PROD_W-1:0]          product_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_lo_s1 <= (QTY_W + RateLoW)'(qty) * (QTY_W + RateLoW)'(rate[RateLoW-1:0]);
		pp_hi_s1 <= (QTY_W + RateHiW)'(qty) * (QTY_W + RateHiW)'(rate[RATE_W-1:RateLoW]);
		product_s2 <= sum[FRACTION_BITS +: PROD_W];
	end

	assign sum     = SUM_W'(pp_lo_s1) + (SUM_W'(pp_hi_s1) << RateLoW);
	assign done    = v_s2;
	assign product = product_s2;

endmodule
